@@ rtl/matrix_matrix_product_unit_macros.svh @@
// ----------------------------------------------------------------------------
// matrix_matrix_product_unit_macros
// assertion macros shared by the matrix product unit
// ----------------------------------------------------------------------------
`ifndef MATRIX_MATRIX_PRODUCT_UNIT_MACROS_SVH
`define MATRIX_MATRIX_PRODUCT_UNIT_MACROS_SVH

// same-cycle implication
`define MMP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mmp_pkg.sv @@
// ----------------------------------------------------------------------------
// mmp_pkg
// types and fixed constants of the matrix product unit
// ----------------------------------------------------------------------------
`default_nettype none

package mmp_pkg;

  localparam int ZW        = 38;
  localparam int OUT_IDX_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_Y    = 2'd2;

  localparam logic ACT_X = 1'b0;
  localparam logic ACT_Y = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

  typedef struct packed {
    logic mac_en;
    logic rd_en;
    logic clr_row;
    logic clr_all;
  } acc_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/mmp_xstore.sv @@
// ----------------------------------------------------------------------------
// mmp_xstore
// column-major store of the x matrix, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_xstore #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire  [$clog2(MAX_DIM*MAX_DIM)-1:0] waddr_i,
  input  wire  signed [ELEM_BITS-1:0] wdata_i,
  input  wire                        re_i,
  input  wire  [$clog2(MAX_DIM*MAX_DIM)-1:0] raddr_i,
  output logic signed [ELEM_BITS-1:0] rdata_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;

  logic signed [ELEM_BITS-1:0] mem [Depth];
  logic signed [ELEM_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/mmp_mac.sv @@
// ----------------------------------------------------------------------------
// mmp_mac
// shared multiply-accumulate unit with the per-row accumulator memory
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_mac import mmp_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  acc_ctrl_t                   ctrl_i,
  input  wire  [$clog2(MAX_DIM)-1:0]  row_i,
  input  wire  signed [ELEM_BITS-1:0] x_data_i,
  input  wire  signed [ELEM_BITS-1:0] y_elem_i,
  output logic signed [ZW-1:0]        acc_data_o
);

  localparam int RowW = $clog2(MAX_DIM);
  localparam int PW   = 2 * ELEM_BITS;
  localparam int ExtW = (PW > ZW) ? PW : ZW;

  logic signed [ZW-1:0]   acc_mem [MAX_DIM];
  logic [MAX_DIM-1:0]     valid_q;
  logic signed [ZW-1:0]   acc_rd_q;
  logic                   vrd_q;
  logic                   v1_q, v2_q;
  logic [RowW-1:0]        row1_q, row2_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [ZW-1:0]   acc_hold_q;
  logic signed [ExtW-1:0] prod_ext;
  logic signed [ZW-1:0]   sum;

  assign prod_ext = ExtW'(prod_q);
  assign sum      = acc_hold_q + prod_ext[ZW-1:0];

  // stage 0: read accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      acc_rd_q <= acc_mem[row_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vrd_q   <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_q <= '0;
    end else begin
      v1_q <= ctrl_i.mac_en;
      v2_q <= v1_q;
      if (ctrl_i.rd_en) begin
        vrd_q <= valid_q[row_i];
      end
      if (ctrl_i.clr_all) begin
        valid_q <= '0;
      end else begin
        if (v2_q) begin
          valid_q[row2_q] <= 1'b1;
        end
        if (ctrl_i.clr_row) begin
          valid_q[row_i] <= 1'b0;
        end
      end
    end
  end

  // stage 1: multiply, stage 2: add and write back
  always_ff @(posedge clk_i) begin
    row1_q <= row_i;
    if (v1_q) begin
      prod_q     <= x_data_i * y_elem_i;
      acc_hold_q <= vrd_q ? acc_rd_q : '0;
      row2_q     <= row1_q;
    end
    if (v2_q) begin
      acc_mem[row2_q] <= sum;
    end
  end

  assign acc_data_o = vrd_q ? acc_rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/mmp_seq.sv @@
// ----------------------------------------------------------------------------
// mmp_seq
// sequencer: configuration, position counters, mac issue and result output
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_matrix_product_unit_macros.svh"

module mmp_seq import mmp_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [CFG_W-1:0]             cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          action_i,
  input  wire  signed [ELEM_BITS-1:0]  element_value_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic signed [ZW-1:0]         z_value_o,
  output logic [OUT_IDX_W-1:0]         z_row_o,
  output logic [OUT_IDX_W-1:0]         z_col_o,
  output logic                         column_last_o,
  output logic                         matrix_last_o,
  output logic                         xs_we_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] xs_waddr_o,
  output logic                         xs_re_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] xs_raddr_o,
  output acc_ctrl_t                    acc_ctrl_o,
  output logic [$clog2(MAX_DIM)-1:0]   acc_row_o,
  output logic signed [ELEM_BITS-1:0]  y_elem_o,
  input  wire  signed [ZW-1:0]         acc_data_i
);

  localparam int XAW  = $clog2(MAX_DIM * MAX_DIM);
  localparam int NkW  = XAW + 1;
  localparam int RowW = $clog2(MAX_DIM);
  localparam int DimW = $clog2(MAX_DIM + 1);

  function automatic logic [DimW-1:0] dim_eff(input logic [CFG_W-1:0] r);
    if (r == '0) begin
      return DimW'(1);
    end else if (32'(r) > MAX_DIM) begin
      return DimW'(MAX_DIM);
    end else begin
      return DimW'(r);
    end
  endfunction

  state_e                      state_q, state_d;
  logic [CFG_W-1:0]            rows_q, rows_d, inner_q, inner_d, cols_q, cols_d;
  logic [XAW-1:0]              x_pos_q, x_pos_d;
  logic [RowW-1:0]             yrow_q, yrow_d, ycol_q, ycol_d, r_q, r_d;
  logic                        coldone_q, coldone_d;
  logic [XAW-1:0]              base_q, base_d;
  logic signed [ELEM_BITS-1:0] y_q, y_d;
  logic                        out_valid_q, out_valid_d;
  logic signed [ZW-1:0]        zval_q, zval_d;
  logic [OUT_IDX_W-1:0]        zrow_q, zrow_d, zcol_q, zcol_d;
  logic                        column_last_q, column_last_d;
  logic                        matrix_last_q, matrix_last_d;

  logic [DimW-1:0] n_eff, k_eff, m_eff;
  logic [NkW-1:0]  nk, x_next;
  logic            r_last, col_last, cfg_hit;

  assign n_eff    = dim_eff(rows_q);
  assign k_eff    = dim_eff(inner_q);
  assign m_eff    = dim_eff(cols_q);
  assign nk       = NkW'(NkW'(n_eff) * NkW'(k_eff));
  assign x_next   = NkW'(x_pos_q) + NkW'(1);
  assign r_last   = (DimW'(r_q) + DimW'(1)) == n_eff;
  assign col_last = (DimW'(ycol_q) + DimW'(1)) == m_eff;

  always_comb begin
    state_d       = state_q;
    rows_d        = rows_q;
    inner_d       = inner_q;
    cols_d        = cols_q;
    x_pos_d       = x_pos_q;
    yrow_d        = yrow_q;
    ycol_d        = ycol_q;
    r_d           = r_q;
    coldone_d     = coldone_q;
    base_d        = base_q;
    y_d           = y_q;
    out_valid_d   = out_valid_q;
    zval_d        = zval_q;
    zrow_d        = zrow_q;
    zcol_d        = zcol_q;
    column_last_d = column_last_q;
    matrix_last_d = matrix_last_q;
    acc_ctrl_o    = '0;
    xs_we_o       = 1'b0;
    xs_re_o       = 1'b0;
    in_ready_o    = 1'b0;
    cfg_hit       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ACT_X) begin
            xs_we_o = 1'b1;
            x_pos_d = (x_next >= nk) ? '0 : x_next[XAW-1:0];
          end else begin
            y_d       = element_value_i;
            base_d    = XAW'(XAW'(yrow_q) * XAW'(n_eff));
            coldone_d = (DimW'(yrow_q) + DimW'(1)) == k_eff;
            yrow_d    = coldone_d ? '0 : yrow_q + RowW'(1);
            r_d       = '0;
            state_d   = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        acc_ctrl_o.mac_en = 1'b1;
        acc_ctrl_o.rd_en  = 1'b1;
        xs_re_o           = 1'b1;
        if (r_last) begin
          r_d     = '0;
          state_d = ST_DRAIN1;
        end else begin
          r_d = r_q + RowW'(1);
        end
      end
      ST_DRAIN1: begin
        state_d = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_d = coldone_q ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        acc_ctrl_o.rd_en   = 1'b1;
        acc_ctrl_o.clr_row = 1'b1;
        state_d            = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          zval_d        = acc_data_i;
          zrow_d        = OUT_IDX_W'(r_q);
          zcol_d        = OUT_IDX_W'(ycol_q);
          column_last_d = r_last;
          matrix_last_d = r_last && col_last;
          if (r_last) begin
            r_d     = '0;
            ycol_d  = col_last ? '0 : ycol_q + RowW'(1);
            state_d = ST_IDLE;
          end else begin
            r_d     = r_q + RowW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // configuration write restarts the counters and the sums
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROWS_X: begin
          rows_d  = cfg_data_i;
          cfg_hit = 1'b1;
        end
        CFG_INNER_DIM: begin
          inner_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        CFG_COLS_Y: begin
          cols_d  = cfg_data_i;
          cfg_hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cfg_hit) begin
      x_pos_d            = '0;
      yrow_d             = '0;
      ycol_d             = '0;
      acc_ctrl_o.clr_all = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= CFG_RESET;
      inner_q     <= CFG_RESET;
      cols_q      <= CFG_RESET;
      x_pos_q     <= '0;
      yrow_q      <= '0;
      ycol_q      <= '0;
      r_q         <= '0;
      coldone_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      inner_q     <= inner_d;
      cols_q      <= cols_d;
      x_pos_q     <= x_pos_d;
      yrow_q      <= yrow_d;
      ycol_q      <= ycol_d;
      r_q         <= r_d;
      coldone_q   <= coldone_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q        <= base_d;
    y_q           <= y_d;
    zval_q        <= zval_d;
    zrow_q        <= zrow_d;
    zcol_q        <= zcol_d;
    column_last_q <= column_last_d;
    matrix_last_q <= matrix_last_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign xs_waddr_o    = x_pos_q;
  assign xs_raddr_o    = base_q + XAW'(r_q);
  assign acc_row_o     = r_q;
  assign y_elem_o      = y_q;
  assign out_valid_o   = out_valid_q;
  assign z_value_o     = zval_q;
  assign z_row_o       = zrow_q;
  assign z_col_o       = zcol_q;
  assign column_last_o = column_last_q;
  assign matrix_last_o = matrix_last_q;

  `MMP_ASSERT_IMPL(a_mac_row_range, state_q == ST_MAC, DimW'(r_q) < n_eff, "mac row past rows_x")
  `MMP_ASSERT_IMPL(a_xpos_range, 1'b1, NkW'(x_pos_q) < nk, "x write position past x size")
  `MMP_ASSERT_NEXT(a_drain_after_mac, (state_q == ST_MAC) && r_last, state_q == ST_DRAIN1, "no drain after last mac")
  `MMP_ASSERT_IMPL(a_last_flags, out_valid_q && matrix_last_q, column_last_q, "matrix end without column end")

endmodule

`default_nettype wire

@@ rtl/matrix_matrix_product_unit.sv @@
// ----------------------------------------------------------------------------
// matrix_matrix_product_unit
// z = x * y, column-major, on one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// an x word is written straight to the x store; a y word runs one mac per row of
// x through the shared multiplier, then the drain states ST_DRAIN1 and ST_DRAIN2
// the y word that ends a column then emits each z row: accumulator memory read,
// then load of the output register, held while the output is stalled
// reset: all three size registers to 16, counters and row sums to zero (valid
// bits); the x store is not cleared and needs no clearing pass
`default_nettype none

module matrix_matrix_product_unit import mmp_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [CFG_W-1:0]             cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          action_i,
  input  wire  signed [ELEM_BITS-1:0]  element_value_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic signed [ZW-1:0]         z_value_o,
  output logic [OUT_IDX_W-1:0]         z_row_o,
  output logic [OUT_IDX_W-1:0]         z_col_o,
  output logic                         column_last_o,
  output logic                         matrix_last_o
);

  localparam int XAW  = $clog2(MAX_DIM * MAX_DIM);
  localparam int RowW = $clog2(MAX_DIM);

  logic                        xs_we, xs_re;
  logic [XAW-1:0]              xs_waddr, xs_raddr;
  logic signed [ELEM_BITS-1:0] xs_rdata, y_elem;
  acc_ctrl_t                   acc_ctrl;
  logic [RowW-1:0]             acc_row;
  logic signed [ZW-1:0]        acc_data;

  mmp_seq #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .z_value_o       (z_value_o),
    .z_row_o         (z_row_o),
    .z_col_o         (z_col_o),
    .column_last_o   (column_last_o),
    .matrix_last_o   (matrix_last_o),
    .xs_we_o         (xs_we),
    .xs_waddr_o      (xs_waddr),
    .xs_re_o         (xs_re),
    .xs_raddr_o      (xs_raddr),
    .acc_ctrl_o      (acc_ctrl),
    .acc_row_o       (acc_row),
    .y_elem_o        (y_elem),
    .acc_data_i      (acc_data)
  );

  mmp_xstore #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_xstore (
    .clk_i   (clk_i),
    .we_i    (xs_we),
    .waddr_i (xs_waddr),
    .wdata_i (element_value_i),
    .re_i    (xs_re),
    .raddr_i (xs_raddr),
    .rdata_o (xs_rdata)
  );

  mmp_mac #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .row_i      (acc_row),
    .x_data_i   (xs_rdata),
    .y_elem_i   (y_elem),
    .acc_data_o (acc_data)
  );

endmodule

`default_nettype wire
